FILE: sv/waveform_min_max_decimator_macros.svh
// Assertion macros of the waveform decimator RTL.
`ifndef WAVEFORM_MIN_MAX_DECIMATOR_MACROS_SVH
`define WAVEFORM_MIN_MAX_DECIMATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at each rising edge, off while reset is applied.
`define WMMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("waveform decimator check failed");
// Checks a property at each rising edge, during reset as well.
`define WMMD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("waveform decimator check failed");
`else
`define WMMD_ASSERT(lbl, clk, rstn, prop)
`define WMMD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/wmmd_pkg.sv
// Types, constants and control structs of the waveform min/max decimator.
`default_nettype none
package wmmd_pkg;

  // Block limits and fixed-point format.
  localparam int unsigned MAX_WINDOW     = 1048576;
  localparam int unsigned MAX_POINTS     = 4096;
  localparam int unsigned MEAN_FRAC_BITS = 8;

  // Field and state widths.
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned PH_W   = 15;
  localparam int unsigned SUMP_W = 35;
  localparam int unsigned SUMN_W = 36;
  localparam int unsigned CNT_W  = 21;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned MH_W   = 23;
  localparam int unsigned ML_W   = 24;

  // Divider geometry: the quotient never needs more than QUOT_W bits.
  localparam int unsigned DVD_W   = SUMN_W + MEAN_FRAC_BITS;
  localparam int unsigned QUOT_W  = 24;
  localparam int unsigned STEP_W  = $clog2(QUOT_W);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic        [PH_W-1:0]  peak_high;
    logic signed [SMP_W-1:0] peak_low;
    logic        [MH_W-1:0]  mean_high;
    logic signed [ML_W-1:0]  mean_low;
    logic        [IDX_W-1:0] point_index;
    logic                    range_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DELIVER
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/wmmd_ctrl.sv
// Controller of the waveform decimator: sample intake, division and delivery.
`default_nettype none
`include "waveform_min_max_decimator_macros.svh"
module wmmd_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wmmd_pkg::sts_t   sts_i,
  output wmmd_pkg::cmd_t   cmd_o
);
  import wmmd_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.close) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DELIVER: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A transfer that closes a window starts the division.
  `WMMD_ASSERT(a_close_divides, clk_i, rst_ni, in_fire && sts_i.close |=> state_q == ST_DIVIDE)
  // A finished point leaves as soon as the output slot is free.
  `WMMD_ASSERT(a_deliver_idle, clk_i, rst_ni,
               cmd_o.out_load |=> state_q == ST_IDLE && in_ready_o)
  // No sample is taken while a division or delivery is pending.
  `WMMD_ASSERT(a_no_take_busy, clk_i, rst_ni,
               (cmd_o.div_step || cmd_o.out_load) |-> !cmd_o.take && !in_ready_o)

endmodule
`default_nettype wire

FILE: sv/wmmd_dpath.sv
// Datapath of the waveform decimator: accumulators, two serial dividers, output register.
`default_nettype none
module wmmd_dpath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [20:0]           cfg_wdata_i,
  input  wmmd_pkg::in_item_t   in_data_i,
  input  wmmd_pkg::cmd_t       cmd_i,
  output wmmd_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output wmmd_pkg::out_item_t  out_data_o
);
  import wmmd_pkg::*;

  // Configuration and window state.
  logic [LEN_W-1:0]        len_q;
  logic [LEN_W-1:0]        fill_q, fill_n, eff_len;
  logic [PH_W-1:0]         ph_q, ph_n;
  logic signed [SMP_W-1:0] pl_q, pl_n;
  logic [SUMP_W-1:0]       sp_q, sp_n;
  logic [SUMN_W-1:0]       sn_q, sn_n;
  logic [CNT_W-1:0]        cp_q, cp_n, cn_q, cn_n;
  logic [IDX_W-1:0]        pts_q;

  // Point under division.
  logic [PH_W-1:0]         hold_ph_q;
  logic signed [SMP_W-1:0] hold_pl_q;
  logic [IDX_W-1:0]        hold_idx_q;
  logic                    hold_last_q;
  logic [CNT_W-1:0]        dvp_q, dvn_q;
  logic [CNT_W-1:0]        remp_q, remn_q;
  logic [QUOT_W-1:0]       qp_q, qn_q;
  logic [STEP_W-1:0]       step_q;

  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    pos, close;
  logic [SMP_W:0]          mag;
  logic [DVD_W-1:0]        dvdp, dvdn;
  logic [CNT_W:0]          tp, tn, dp, dn;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = len_q;
    end
  end

  // Window update for the incoming sample.
  always_comb begin
    pos    = !in_data_i.sample[SMP_W-1] && (in_data_i.sample != '0);
    mag    = (SMP_W+1)'(0) - {in_data_i.sample[SMP_W-1], in_data_i.sample};
    ph_n   = ph_q;
    pl_n   = pl_q;
    sp_n   = sp_q;
    sn_n   = sn_q;
    cp_n   = cp_q;
    cn_n   = cn_q;
    if (pos) begin
      if (in_data_i.sample[PH_W-1:0] > ph_q) ph_n = in_data_i.sample[PH_W-1:0];
      sp_n = sp_q + SUMP_W'(in_data_i.sample[PH_W-1:0]);
      cp_n = cp_q + CNT_W'(1);
    end else begin
      if (in_data_i.sample < pl_q) pl_n = in_data_i.sample;
      sn_n = sn_q + SUMN_W'(mag);
      cn_n = cn_q + CNT_W'(1);
    end
    fill_n = fill_q + LEN_W'(1);
    close  = (fill_n >= eff_len) || in_data_i.last;
    dvdp   = {DVD_W'(sp_n)} << MEAN_FRAC_BITS;
    dvdn   = {DVD_W'(sn_n)} << MEAN_FRAC_BITS;
  end

  // One restoring step for each divider.
  always_comb begin
    tp = {remp_q, qp_q[QUOT_W-1]};
    tn = {remn_q, qn_q[QUOT_W-1]};
    dp = tp - {1'b0, dvp_q};
    dn = tn - {1'b0, dvn_q};
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Accumulators and point counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ph_q   <= '0;
      pl_q   <= '0;
      sp_q   <= '0;
      sn_q   <= '0;
      cp_q   <= '0;
      cn_q   <= '0;
      pts_q  <= '0;
    end else if (cmd_i.take) begin
      if (close) begin
        fill_q <= '0;
        ph_q   <= '0;
        pl_q   <= '0;
        sp_q   <= '0;
        sn_q   <= '0;
        cp_q   <= '0;
        cn_q   <= '0;
        if (in_data_i.last || (pts_q == IDX_W'(MAX_POINTS - 1))) begin
          pts_q <= '0;
        end else begin
          pts_q <= pts_q + IDX_W'(1);
        end
      end else begin
        fill_q <= fill_n;
        ph_q   <= ph_n;
        pl_q   <= pl_n;
        sp_q   <= sp_n;
        sn_q   <= sn_n;
        cp_q   <= cp_n;
        cn_q   <= cn_n;
      end
    end
  end

  // Division step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.take) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Divider operands, quotients and the held point fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && close) begin
      hold_ph_q   <= ph_n;
      hold_pl_q   <= pl_n;
      hold_idx_q  <= pts_q;
      hold_last_q <= in_data_i.last;
      dvp_q       <= cp_n;
      dvn_q       <= cn_n;
      remp_q      <= CNT_W'(dvdp[DVD_W-1:QUOT_W]);
      remn_q      <= CNT_W'(dvdn[DVD_W-1:QUOT_W]);
      qp_q        <= dvdp[QUOT_W-1:0];
      qn_q        <= dvdn[QUOT_W-1:0];
    end else if (cmd_i.div_step) begin
      if (!dp[CNT_W]) begin
        remp_q <= dp[CNT_W-1:0];
        qp_q   <= {qp_q[QUOT_W-2:0], 1'b1};
      end else begin
        remp_q <= tp[CNT_W-1:0];
        qp_q   <= {qp_q[QUOT_W-2:0], 1'b0};
      end
      if (!dn[CNT_W]) begin
        remn_q <= dn[CNT_W-1:0];
        qn_q   <= {qn_q[QUOT_W-2:0], 1'b1};
      end else begin
        remn_q <= tn[CNT_W-1:0];
        qn_q   <= {qn_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; an empty count gives a zero mean.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.peak_high   <= hold_ph_q;
      out_q.peak_low    <= hold_pl_q;
      out_q.mean_high   <= (dvp_q == '0) ? '0 : qp_q[MH_W-1:0];
      out_q.mean_low    <= (dvn_q == '0) ? '0 : ML_W'(ML_W'(0) - qn_q[ML_W-1:0]);
      out_q.point_index <= hold_idx_q;
      out_q.range_end   <= hold_last_q;
    end
  end

  assign sts_o.close    = close;
  assign sts_o.div_done = cmd_i.div_step && (step_q == STEP_W'(QUOT_W - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

FILE: sv/waveform_min_max_decimator.sv
// Top level of the waveform min/max decimator.
// Each sample is one transfer on the input channel; one that does not close a
// window only updates the accumulators and does not stall the intake. A sample
// that closes a window (window length reached or last set) starts two 24-step
// serial dividers that form both averages; no further sample is taken until the
// division is done and the point is loaded into the output register, which
// waits for the register to be free. The finished point then waits there, and
// the next samples are accepted while it is not yet taken. A window length of
// zero acts as one and lengths above 1048576 are saturated. Write window_len
// only while no point is pending.
`default_nettype none
module waveform_min_max_decimator (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [20:0]           cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wmmd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output wmmd_pkg::out_item_t  out_data_o
);
  import wmmd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer for intake, division and delivery.
  wmmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Accumulators, dividers and output register.
  wmmd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
